@@ rtl/nsf_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes and arithmetic steps of the nonlinear spring force block.
// No dependencies; every other file of the block imports this package.
package nsf_pkg;

    // Fixed point
    localparam int FRAC_BITS = 16;

    // Field and datapath widths
    localparam int IN_W      = 32;              // point and anchor coordinates
    localparam int R_W       = IN_W + 1;        // exact offset, signed
    localparam int M_W       = R_W;             // offset magnitude, unsigned
    localparam int SQ_W      = 2 * M_W;         // square of a magnitude, sum of three
    localparam int H_W       = 31;              // offset height
    localparam int H2_W      = 2 * H_W;
    localparam int L0_W      = 31;              // rest length
    localparam int K_W       = 32;              // stiffness
    localparam int RAD_W     = SQ_W;            // radicand
    localparam int ROOT_W    = RAD_W / 2;       // root
    localparam int REM_W     = ROOT_W + 2;      // root remainder
    localparam int DV_W      = ROOT_W;          // divisor (d or s)
    localparam int E_W       = ROOT_W;          // |s - L0|, |d - L0|
    localparam int P_W       = 2 * E_W;         // their product
    localparam int T_W       = 62;              // quotient t, below 2^62
    localparam int U_W       = T_W + K_W;       // t * k
    localparam int F_W       = U_W - FRAC_BITS + 1;
    localparam int FC_W      = (F_W + 2) / 3;   // chunk of f per partial product
    localparam int FP_W      = 3 * FC_W;
    localparam int N_W       = F_W + M_W;       // f * |r_i|
    localparam int FORCE_W   = 48;
    localparam int Q_W       = FORCE_W;         // quotient bits kept per component
    localparam int NH_W      = N_W - Q_W;
    localparam int LEN_W     = 34;
    localparam int CFG_IDX_W = 3;

    // Pipeline depths
    localparam int SQRT_LAT = ROOT_W;
    localparam int QDIV_LAT = T_W;
    localparam int FDIV_LAT = Q_W + 2;

    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANCHOR_X    = 3'd0,
        CFG_ANCHOR_Y    = 3'd1,
        CFG_ANCHOR_Z    = 3'd2,
        CFG_STIFFNESS   = 3'd3,
        CFG_HEIGHT      = 3'd4,
        CFG_REST_LENGTH = 3'd5
    } t_cfg_idx;

    // One digit of the square root
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_root_st;

    // One bit of a restoring division
    typedef struct packed {
        logic            q;
        logic [DV_W-1:0] rem;
    } t_div_st;

    // Per-component flags that ride along the force divider
    typedef struct packed {
        logic neg;
        logic zero;
    } t_force_flags;

    function automatic t_root_st sqrt_step(input t_root_st st);
        logic [REM_W+1:0] rs;
        logic [REM_W+1:0] trial;
        t_root_st         nx;
        rs      = {st.rem, st.rad[RAD_W-1 -: 2]};
        trial   = {2'b00, st.root, 2'b01};
        nx.rad  = {st.rad[RAD_W-3:0], 2'b00};
        if (rs >= trial) begin
            nx.rem  = REM_W'(rs - trial);
            nx.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            nx.rem  = rs[REM_W-1:0];
            nx.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    function automatic t_div_st div_step(input logic [DV_W-1:0] rem, input logic nb,
                                         input logic [DV_W-1:0] dv);
        logic [DV_W:0] rs;
        t_div_st       r;
        rs = {rem, nb};
        if (rs >= {1'b0, dv}) begin
            r.q   = 1'b1;
            r.rem = DV_W'(rs - {1'b0, dv});
        end else begin
            r.q   = 1'b0;
            r.rem = rs[DV_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/nsf_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on nsf_pkg (widths, sqrt_step).
module nsf_sqrt_pipe (
    input  logic                        i_clk,
    input  logic [nsf_pkg::RAD_W-1:0]   i_rad,
    output logic [nsf_pkg::ROOT_W-1:0]  o_root
);
    import nsf_pkg::*;

    t_root_st r_st [0:SQRT_LAT-1];
    t_root_st w_init;

    // Start with empty remainder and root
    always_comb begin
        w_init.rem  = '0;
        w_init.root = '0;
        w_init.rad  = i_rad;
    end

    for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
        t_root_st n_st;
        if (j == 0) begin : g_first
            assign n_st = sqrt_step(w_init);
        end else begin : g_next
            assign n_st = sqrt_step(r_st[j-1]);
        end
        // Advance one digit
        always_ff @(posedge i_clk) begin
            r_st[j] <= n_st;
        end
    end

    assign o_root = r_st[SQRT_LAT-1].root;

endmodule

@@ rtl/nsf_quot_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for t = |e1|*|e2| / s, one quotient bit per stage.
// Depends on nsf_pkg (widths, div_step).
module nsf_quot_div (
    input  logic                       i_clk,
    input  logic [nsf_pkg::P_W-1:0]    i_num,
    input  logic [nsf_pkg::DV_W-1:0]   i_dv,
    output logic [nsf_pkg::T_W-1:0]    o_quo
);
    import nsf_pkg::*;

    // Numerator bits shift out at the top while quotient bits enter at the bottom
    logic [DV_W-1:0] r_rem [0:QDIV_LAT-2];
    logic [T_W-1:0]  r_nq  [0:QDIV_LAT-1];
    logic [DV_W-1:0] r_dv  [0:QDIV_LAT-2];

    for (genvar j = 0; j < QDIV_LAT; j++) begin : g_stage
        logic [DV_W-1:0] w_rem_p;
        logic [DV_W-1:0] w_dv_p;
        logic [T_W-1:0]  w_nq_p;
        t_div_st         n_st;

        if (j == 0) begin : g_first
            // Quotient fits in T_W bits, so the top part is below the divisor
            assign w_rem_p = DV_W'(i_num[P_W-1:T_W]);
            assign w_nq_p  = i_num[T_W-1:0];
            assign w_dv_p  = i_dv;
        end else begin : g_next
            assign w_rem_p = r_rem[j-1];
            assign w_nq_p  = r_nq[j-1];
            assign w_dv_p  = r_dv[j-1];
        end

        assign n_st = div_step(w_rem_p, w_nq_p[T_W-1], w_dv_p);

        always_ff @(posedge i_clk) begin
            r_nq[j] <= {w_nq_p[T_W-2:0], n_st.q};
        end

        if (j < QDIV_LAT - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j] <= n_st.rem;
                r_dv[j]  <= w_dv_p;
            end
        end
    end

    assign o_quo = r_nq[QDIV_LAT-1];

endmodule

@@ rtl/nsf_force_div.sv @@
`timescale 1ns / 1ps
// One force component: f*|r_i| / d with overflow detect, sign and 48-bit saturation.
// Depends on nsf_pkg (widths, div_step, t_force_flags, saturation limits).
module nsf_force_div (
    input  logic                          i_clk,
    input  logic [nsf_pkg::N_W-1:0]       i_num,
    input  logic [nsf_pkg::DV_W-1:0]      i_dv,
    input  nsf_pkg::t_force_flags         i_flags,
    output logic [nsf_pkg::FORCE_W-1:0]   o_force
);
    import nsf_pkg::*;

    logic [DV_W-1:0]    r_rem   [0:Q_W-1];
    logic [Q_W-1:0]     r_nq    [0:Q_W];
    logic [DV_W-1:0]    r_dv    [0:Q_W-1];
    logic               r_ovf   [0:Q_W];
    t_force_flags       r_flags [0:Q_W];
    logic [FORCE_W-1:0] r_force;
    logic [FORCE_W-1:0] n_force;

    // Front stage: quotient of 2^Q_W or more saturates whatever the sign, unless the zero flag forces zero
    always_ff @(posedge i_clk) begin
        r_ovf[0]   <= (i_num[N_W-1:Q_W] >= NH_W'(i_dv));
        r_rem[0]   <= i_num[Q_W+DV_W-1:Q_W];
        r_nq[0]    <= i_num[Q_W-1:0];
        r_dv[0]    <= i_dv;
        r_flags[0] <= i_flags;
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_stage
        t_div_st n_st;
        assign n_st = div_step(r_rem[j-1], r_nq[j-1][Q_W-1], r_dv[j-1]);

        always_ff @(posedge i_clk) begin
            r_nq[j]    <= {r_nq[j-1][Q_W-2:0], n_st.q};
            r_ovf[j]   <= r_ovf[j-1];
            r_flags[j] <= r_flags[j-1];
        end

        if (j < Q_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j] <= n_st.rem;
                r_dv[j]  <= r_dv[j-1];
            end
        end
    end

    // Apply sign and clamp to the signed 48-bit range
    always_comb begin
        if (r_flags[Q_W].zero) begin
            n_force = '0;
        end else if (!r_flags[Q_W].neg) begin
            n_force = (r_ovf[Q_W] || r_nq[Q_W][Q_W-1]) ? FORCE_MAX : r_nq[Q_W];
        end else if (r_ovf[Q_W] || (r_nq[Q_W] > FORCE_MIN)) begin
            n_force = FORCE_MIN;
        end else begin
            n_force = FORCE_W'(~r_nq[Q_W] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_force <= n_force;
    end

    assign o_force = r_force;

endmodule

@@ rtl/nonlinear_spring_force.sv @@
`timescale 1ns / 1ps
// Nonlinear spring force: top level, input lanes, multipliers and sideband delays.
// Depends on nsf_pkg, nsf_sqrt_pipe, nsf_quot_div and nsf_force_div.
//
// Usage
//   Command channel: a point beat (i_point_x/y/z, signed Q16.16) is taken at each
//   rising edge with start high and busy low. busy never rises, so a new point
//   may be presented every cycle.
//   Result channel: o_valid is high for exactly one cycle with o_force_x/y/z
//   (signed Q32.16, saturated) and o_spring_length (Q18.16). The receiver cannot
//   stall; each result must be taken in the cycle it is shown.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data writes one register;
//   o_cfg_ready is always high. Write only while no point is in flight.
// Timing
//   From the accepting edge to the edge that takes the result a point passes:
//   input and square stages (5), two 33-stage root pipelines in parallel, three
//   stretch and product stages, the 62-stage divider for the stretch term, four
//   scaling stages and a 50-stage divider per component. Throughput is one
//   point per cycle.
// Reset
//   i_rst_n (synchronous, active low) clears the configuration registers and
//   drops every point in flight; no result appears for them.
module nonlinear_spring_force
    import nsf_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [IN_W-1:0]       i_point_x,
    input  logic signed [IN_W-1:0]       i_point_y,
    input  logic signed [IN_W-1:0]       i_point_z,
    output logic                         o_valid,
    output logic signed [FORCE_W-1:0]    o_force_x,
    output logic signed [FORCE_W-1:0]    o_force_y,
    output logic signed [FORCE_W-1:0]    o_force_z,
    output logic [LEN_W-1:0]             o_spring_length,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [IN_W-1:0]              i_cfg_data
);

    // Stage numbers, counted in edges after acceptance
    localparam int C_B   = 2;
    localparam int C_E   = 5;
    localparam int C_SQ  = C_E + SQRT_LAT;
    localparam int C_G   = C_SQ + 1;
    localparam int C_I   = C_G + 2;
    localparam int C_T   = C_I + QDIV_LAT;
    localparam int C_K   = C_T + 2;
    localparam int C_M   = C_K + 2;
    localparam int C_OUT = C_M + FDIV_LAT;
    localparam int E_LO  = E_W / 2 + 1;
    localparam int T_LO  = T_W / 2;

    localparam int MAG_DLY = C_K - C_B;
    localparam int NEG_DLY = C_K - C_G;
    localparam int LEN_DLY = C_OUT - C_SQ;

    typedef struct packed {
        logic           sgn;
        logic [M_W-1:0] mag;
    } t_lane;

    logic               w_accept;
    logic [IN_W-1:0]    w_pt [0:2];

    logic [IN_W-1:0]    r_anchor [0:2];
    logic [K_W-1:0]     r_stiffness;
    logic [H_W-1:0]     r_height;
    logic [L0_W-1:0]    r_rest_len;

    logic               r_vld [0:C_OUT-1];

    logic [R_W-1:0]     r_a_r   [0:2];
    t_lane              r_b_lane [0:2];
    logic [SQ_W-1:0]    r_c_sq  [0:2];
    logic [H2_W-1:0]    r_c_h2;
    logic [SQ_W-1:0]    r_d_d2;
    logic [H2_W-1:0]    r_d_h2;
    logic [RAD_W-1:0]   r_e_d2;
    logic [RAD_W-1:0]   r_e_s2;

    logic [ROOT_W-1:0]  w_d;
    logic [ROOT_W-1:0]  w_s;
    logic [E_W:0]       w_e1;
    logic [E_W:0]       w_e2;

    logic [E_W-1:0]     r_g_e1m;
    logic [E_W-1:0]     r_g_e2m;
    logic               r_g_neg;
    logic [DV_W-1:0]    r_g_s;
    logic [E_W+E_LO-1:0]          r_h_pa;
    logic [2*E_W-E_LO-1:0]        r_h_pb;
    logic [DV_W-1:0]    r_h_s;
    logic [P_W-1:0]     r_i_p;
    logic [DV_W-1:0]    r_i_s;

    logic [T_W-1:0]     w_t;
    logic [T_LO+K_W-1:0]          r_j_ua;
    logic [T_W-T_LO+K_W-1:0]      r_j_ub;
    logic [U_W-1:0]     w_u;
    logic [F_W-1:0]     r_k_f;
    logic [FP_W-1:0]    w_fpad;

    logic [FC_W+M_W-1:0] r_l_pp [0:2][0:2];
    logic               r_l_neg [0:2];
    logic [N_W-1:0]     r_m_n   [0:2];
    logic               r_m_neg [0:2];

    t_lane              r_mag_dly [0:MAG_DLY-1][0:2];
    logic               r_neg_dly [0:NEG_DLY-1];
    logic [ROOT_W-1:0]  r_len_dly [0:LEN_DLY-1];

    logic [ROOT_W-1:0]  w_d_m;
    logic [FORCE_W-1:0] w_force [0:2];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor[0] <= '0;
            r_anchor[1] <= '0;
            r_anchor[2] <= '0;
            r_stiffness <= '0;
            r_height    <= '0;
            r_rest_len  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ANCHOR_X:    r_anchor[0] <= i_cfg_data;
                CFG_ANCHOR_Y:    r_anchor[1] <= i_cfg_data;
                CFG_ANCHOR_Z:    r_anchor[2] <= i_cfg_data;
                CFG_STIFFNESS:   r_stiffness <= i_cfg_data;
                CFG_HEIGHT:      r_height    <= i_cfg_data[H_W-1:0];
                CFG_REST_LENGTH: r_rest_len  <= i_cfg_data[L0_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < C_OUT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= w_accept;
            for (int k = 1; k < C_OUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Offset, magnitude, squares and sums
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_r[i] <= R_W'($signed({w_pt[i][IN_W-1], w_pt[i]})
                           - $signed({r_anchor[i][IN_W-1], r_anchor[i]}));
            r_b_lane[i].sgn <= r_a_r[i][R_W-1];
            r_b_lane[i].mag <= r_a_r[i][R_W-1] ? M_W'(~r_a_r[i] + 1'b1) : r_a_r[i];
            r_c_sq[i] <= r_b_lane[i].mag * r_b_lane[i].mag;
        end
        r_c_h2 <= r_height * r_height;
        r_d_d2 <= r_c_sq[0] + r_c_sq[1] + r_c_sq[2];
        r_d_h2 <= r_c_h2;
        r_e_d2 <= r_d_d2;
        r_e_s2 <= r_d_d2 + RAD_W'(r_d_h2);
    end

    nsf_sqrt_pipe u_sqrt_d (
        .i_clk  (i_clk),
        .i_rad  (r_e_d2),
        .o_root (w_d)
    );

    nsf_sqrt_pipe u_sqrt_s (
        .i_clk  (i_clk),
        .i_rad  (r_e_s2),
        .o_root (w_s)
    );

    // Stretch terms s - L0 and d - L0
    assign w_e1 = (E_W+1)'({1'b0, w_s}) - (E_W+1)'(r_rest_len);
    assign w_e2 = (E_W+1)'({1'b0, w_d}) - (E_W+1)'(r_rest_len);

    always_ff @(posedge i_clk) begin
        r_g_e1m <= w_e1[E_W] ? E_W'(~w_e1 + 1'b1) : w_e1[E_W-1:0];
        r_g_e2m <= w_e2[E_W] ? E_W'(~w_e2 + 1'b1) : w_e2[E_W-1:0];
        r_g_neg <= w_e1[E_W] ^ w_e2[E_W];
        r_g_s   <= w_s;
        // Product split over two narrow multipliers
        r_h_pa  <= r_g_e1m * r_g_e2m[E_LO-1:0];
        r_h_pb  <= r_g_e1m * r_g_e2m[E_W-1:E_LO];
        r_h_s   <= r_g_s;
        r_i_p   <= P_W'(r_h_pa) + (P_W'(r_h_pb) << E_LO);
        r_i_s   <= r_h_s;
    end

    nsf_quot_div u_quot_div (
        .i_clk (i_clk),
        .i_num (r_i_p),
        .i_dv  (r_i_s),
        .o_quo (w_t)
    );

    // Scale by stiffness, then by two and down by the fraction
    assign w_u    = U_W'(r_j_ua) + (U_W'(r_j_ub) << T_LO);
    assign w_fpad = FP_W'(r_k_f);

    always_ff @(posedge i_clk) begin
        r_j_ua <= w_t[T_LO-1:0] * r_stiffness;
        r_j_ub <= w_t[T_W-1:T_LO] * r_stiffness;
        r_k_f  <= w_u[U_W-1:FRAC_BITS-1];
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                r_l_pp[i][c] <= w_fpad[c*FC_W +: FC_W] * r_mag_dly[MAG_DLY-1][i].mag;
            end
            r_l_neg[i] <= r_neg_dly[NEG_DLY-1] ^ r_mag_dly[MAG_DLY-1][i].sgn;
            r_m_n[i]   <= N_W'(r_l_pp[i][0]) + (N_W'(r_l_pp[i][1]) << FC_W)
                          + (N_W'(r_l_pp[i][2]) << (2 * FC_W));
            r_m_neg[i] <= r_l_neg[i];
        end
    end

    // Sideband delay lines
    always_ff @(posedge i_clk) begin
        r_mag_dly[0] <= r_b_lane;
        for (int k = 1; k < MAG_DLY; k++) r_mag_dly[k] <= r_mag_dly[k-1];
        r_neg_dly[0] <= r_g_neg;
        for (int k = 1; k < NEG_DLY; k++) r_neg_dly[k] <= r_neg_dly[k-1];
        r_len_dly[0] <= w_d;
        for (int k = 1; k < LEN_DLY; k++) r_len_dly[k] <= r_len_dly[k-1];
    end

    assign w_d_m = r_len_dly[C_M - C_SQ - 1];

    for (genvar i = 0; i < 3; i++) begin : g_comp
        t_force_flags w_flags;
        assign w_flags.neg  = r_m_neg[i];
        assign w_flags.zero = (w_d_m == '0);

        nsf_force_div u_force_div (
            .i_clk   (i_clk),
            .i_num   (r_m_n[i]),
            .i_dv    (w_d_m),
            .i_flags (w_flags),
            .o_force (w_force[i])
        );
    end

    assign o_valid         = r_vld[C_OUT-1];
    assign o_force_x       = w_force[0];
    assign o_force_y       = w_force[1];
    assign o_force_z       = w_force[2];
    assign o_spring_length = LEN_W'(r_len_dly[LEN_DLY-1]);

    // Every accepted point yields its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##C_OUT o_valid)
        else $error("result missing after fixed latency");

    // Zero length gives zero force
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_spring_length == '0) |->
        (o_force_x == '0 && o_force_y == '0 && o_force_z == '0))
        else $error("nonzero force at zero spring length");

    // A result only appears for an accepted point
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_accept, C_OUT))
        else $error("result without accepted point");

endmodule
